@@ rtl/mbsp_pkg.sv @@
// Package with the item types, codes and length table of the MIDI byte stream parser.
`timescale 1ns / 1ps

package mbsp_pkg;

  // One incoming MIDI byte with its arrival time.
  typedef struct packed {
    logic [7:0]  byte_value;
    logic [63:0] time_stamp;
  } in_item_t;

  // One byte of an emitted message.
  typedef struct packed {
    logic [7:0]  msg_byte;
    logic        last_of_message;
    logic [63:0] msg_time;
    logic        sysex_truncated;
  } out_item_t;

  localparam logic [7:0] STATUS_BIT     = 8'h80;
  localparam logic [7:0] SYSEX_START    = 8'hF0;
  localparam logic [7:0] SYSEX_END      = 8'hF7;
  localparam logic [7:0] REALTIME_FIRST = 8'hF8;

  // Sources for the output register.
  localparam logic [1:0] SRC_RT   = 2'd0;
  localparam logic [1:0] SRC_HEAD = 2'd1;
  localparam logic [1:0] SRC_RAM  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       take;
    logic       load;
    logic [1:0] src;
    logic       last;
    logic       rd_en;
  } mbsp_cmd_t;

  // Status from the datapath about the item on the input port.
  typedef struct packed {
    logic is_rt;
    logic emit;
  } mbsp_sts_t;

  // Message length in bytes for a status byte; zero means undefined.
  function automatic logic [1:0] msg_length(input logic [7:0] status);
    logic [1:0] len;
    len = 2'd0;
    if (status >= 8'h80 && status < 8'hC0) begin
      len = 2'd3;
    end else if (status >= 8'hC0 && status < 8'hE0) begin
      len = 2'd2;
    end else if (status >= 8'hE0 && status < 8'hF0) begin
      len = 2'd3;
    end else begin
      case (status)
        8'hF1:   len = 2'd2;
        8'hF2:   len = 2'd3;
        8'hF3:   len = 2'd2;
        8'hF6:   len = 2'd1;
        default: len = 2'd0;
      endcase
    end
    return len;
  endfunction

endpackage

@@ rtl/midi_byte_stream_parser_top.sv @@
// Top level of the MIDI byte stream parser with running status.
`timescale 1ns / 1ps

// MIDI byte stream parser. Each input item is one MIDI byte with its arrival
// time; each output item is one byte of a complete message, status byte first,
// with a last mark on its final byte and the time of the byte that completed
// it. Realtime bytes (0xF8 and up) leave as one-byte messages at once. Channel
// messages set running status; system common and sysex statuses cancel it.
// Stray data bytes and undefined statuses are dropped. Sysex is collected in a
// BUFFER_DEPTH-byte buffer until 0xF7; content that does not fit is dropped
// and every byte of that message carries the truncation mark. A byte that does
// not complete a message, and a realtime byte, let the next byte in unless the
// output register is still full. A byte that completes a message holds the input
// off while the message drains: the status byte comes from a register, each
// later byte takes a buffer RAM read and an output register load. Output back
// pressure stalls the drain. The buffer needs no clearing after reset.
module midi_byte_stream_parser_top #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mbsp_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mbsp_pkg::out_item_t out_item_o
);
  import mbsp_pkg::*;

  localparam int AddrW = $clog2(BUFFER_DEPTH);
  localparam int FillW = $clog2(BUFFER_DEPTH + 1);

  mbsp_cmd_t        cmd;
  mbsp_sts_t        sts;
  logic [FillW-1:0] emit_len;
  logic [AddrW-1:0] rd_addr;

  mbsp_ctrl #(
    .BufferDepth(BUFFER_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .emit_len_i (emit_len),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr)
  );

  mbsp_dp #(
    .BufferDepth(BUFFER_DEPTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_item_i (in_item_i),
    .cmd_i     (cmd),
    .rd_addr_i (rd_addr),
    .sts_o     (sts),
    .emit_len_o(emit_len),
    .out_item_o(out_item_o)
  );

endmodule

@@ rtl/mbsp_ram.sv @@
// Generic single-port-write RAM with a registered read port.
`timescale 1ns / 1ps

module mbsp_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/mbsp_dp.sv @@
// Datapath of the MIDI parser: message state, byte buffer and output register.
`timescale 1ns / 1ps

module mbsp_dp #(
  parameter int BufferDepth = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mbsp_pkg::in_item_t               in_item_i,
  input  mbsp_pkg::mbsp_cmd_t              cmd_i,
  input  logic [$clog2(BufferDepth)-1:0]   rd_addr_i,
  output mbsp_pkg::mbsp_sts_t              sts_o,
  output logic [$clog2(BufferDepth+1)-1:0] emit_len_o,
  output mbsp_pkg::out_item_t              out_item_o
);
  import mbsp_pkg::*;

  localparam int AddrW = $clog2(BufferDepth);
  localparam int FillW = $clog2(BufferDepth + 1);
  localparam logic [FillW-1:0] DepthF   = FillW'(BufferDepth);
  localparam logic [FillW-1:0] DepthM1F = FillW'(BufferDepth - 1);

  logic [7:0]       head_q, head_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [7:0]       rs_q, rs_d;
  logic             ovf_q, ovf_d;
  logic [63:0]      time_q;
  logic             trunc_q, trunc_d;
  out_item_t        out_q;

  logic [7:0]       in_byte;
  logic             in_sysex;
  logic             is_rt;
  logic             emit;
  logic [FillW-1:0] emit_len;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [FillW-1:0] fill_base;
  logic [FillW-1:0] fill_new;
  logic             ovf_new;
  logic             dropped;
  logic [1:0]       len;
  logic [7:0]       rd_data;

  assign in_byte  = in_item_i.byte_value;
  assign is_rt    = in_byte >= REALTIME_FIRST;
  assign in_sysex = (fill_q != '0) && (head_q == SYSEX_START);

  // Next message state for the byte on the input port.
  always_comb begin
    head_d    = head_q;
    fill_d    = fill_q;
    rs_d      = rs_q;
    ovf_d     = ovf_q;
    trunc_d   = trunc_q;
    emit      = 1'b0;
    emit_len  = fill_q;
    wr_en     = 1'b0;
    wr_addr   = fill_q[AddrW-1:0];
    fill_base = fill_q;
    fill_new  = fill_q;
    ovf_new   = ovf_q;
    dropped   = 1'b0;
    len       = 2'd0;
    if (is_rt) begin
      // Realtime bytes leave the message state alone.
    end else if (in_sysex) begin
      if (in_byte == SYSEX_END) begin
        emit_len = fill_q;
        if (fill_q < DepthF) begin
          wr_en    = 1'b1;
          emit_len = fill_q + 1'b1;
        end
        emit    = 1'b1;
        fill_d  = '0;
        ovf_d   = 1'b0;
        trunc_d = ovf_q;
      end else if (fill_q < DepthM1F) begin
        wr_en  = 1'b1;
        fill_d = fill_q + 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
    end else begin
      if ((in_byte & STATUS_BIT) != 8'h00) begin
        rs_d     = (in_byte < SYSEX_START) ? in_byte : 8'h00;
        head_d   = in_byte;
        fill_new = FillW'(1);
        ovf_new  = 1'b0;
      end else if (fill_q == '0 && rs_q == 8'h00) begin
        dropped = 1'b1;
      end else begin
        if (fill_q == '0) begin
          head_d    = rs_q;
          fill_base = FillW'(1);
        end
        fill_new = fill_base;
        if (fill_base < DepthF) begin
          wr_en    = 1'b1;
          wr_addr  = fill_base[AddrW-1:0];
          fill_new = fill_base + 1'b1;
        end
      end
      if (!dropped) begin
        len    = msg_length(head_d);
        fill_d = fill_new;
        ovf_d  = ovf_new;
        if (head_d != SYSEX_START) begin
          if (len == 2'd0) begin
            fill_d = '0;
          end else if (fill_new >= {{(FillW-2){1'b0}}, len}) begin
            emit     = 1'b1;
            emit_len = fill_new;
            fill_d   = '0;
            ovf_d    = 1'b0;
            trunc_d  = ovf_new;
          end
        end
      end
    end
  end

  // Message state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= 8'h00;
      fill_q <= '0;
      rs_q   <= 8'h00;
      ovf_q  <= 1'b0;
    end else if (cmd_i.take && !is_rt) begin
      head_q <= head_d;
      fill_q <= fill_d;
      rs_q   <= rs_d;
      ovf_q  <= ovf_d;
    end
  end

  // Time and truncation mark of the message being drained.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && emit && !is_rt) begin
      time_q  <= in_item_i.time_stamp;
      trunc_q <= trunc_d;
    end
  end

  mbsp_ram #(
    .Width(8),
    .Depth(BufferDepth)
  ) u_buf (
    .clk_i    (clk_i),
    .wr_en_i  (cmd_i.take && wr_en && !is_rt),
    .wr_addr_i(wr_addr),
    .wr_data_i(in_byte),
    .rd_en_i  (cmd_i.rd_en),
    .rd_addr_i(rd_addr_i),
    .rd_data_o(rd_data)
  );

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      case (cmd_i.src)
        SRC_RT: begin
          out_q.msg_byte        <= in_byte;
          out_q.last_of_message <= 1'b1;
          out_q.msg_time        <= in_item_i.time_stamp;
          out_q.sysex_truncated <= 1'b0;
        end
        SRC_HEAD: begin
          out_q.msg_byte        <= head_q;
          out_q.last_of_message <= cmd_i.last;
          out_q.msg_time        <= time_q;
          out_q.sysex_truncated <= trunc_q;
        end
        default: begin
          out_q.msg_byte        <= rd_data;
          out_q.last_of_message <= cmd_i.last;
          out_q.msg_time        <= time_q;
          out_q.sysex_truncated <= trunc_q;
        end
      endcase
    end
  end

  assign sts_o.is_rt = is_rt;
  assign sts_o.emit  = emit;
  assign emit_len_o  = emit_len;
  assign out_item_o  = out_q;

endmodule

@@ rtl/mbsp_ctrl.sv @@
// Controller of the MIDI parser: handshakes and the sequencer that drains a message.
`timescale 1ns / 1ps

module mbsp_ctrl #(
  parameter int BufferDepth = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  input  mbsp_pkg::mbsp_sts_t              sts_i,
  input  logic [$clog2(BufferDepth+1)-1:0] emit_len_i,
  output mbsp_pkg::mbsp_cmd_t              cmd_o,
  output logic [$clog2(BufferDepth)-1:0]   rd_addr_o
);
  import mbsp_pkg::*;

  localparam int AddrW = $clog2(BufferDepth);
  localparam int FillW = $clog2(BufferDepth + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DRAIN = 2'd1;
  localparam logic [1:0] S_LOAD  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [FillW-1:0] n_q, n_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;
  logic             accept;
  logic             is_last;
  mbsp_cmd_t        cmd;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign is_last    = (FillW'(idx_q) + 1'b1) == n_q;

  // Sequencer: take an item, then hand out the buffered message byte by byte.
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    n_d       = n_q;
    cmd.take  = 1'b0;
    cmd.load  = 1'b0;
    cmd.src   = SRC_RT;
    cmd.last  = 1'b0;
    cmd.rd_en = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd.take = 1'b1;
          if (sts_i.is_rt) begin
            cmd.load = 1'b1;
            cmd.src  = SRC_RT;
            cmd.last = 1'b1;
          end else if (sts_i.emit) begin
            n_d     = emit_len_i;
            idx_d   = '0;
            state_d = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        if (out_free) begin
          if (idx_q == '0) begin
            // The status byte is held in a register, not in the buffer.
            cmd.load = 1'b1;
            cmd.src  = SRC_HEAD;
            cmd.last = is_last;
            if (is_last) begin
              state_d = S_IDLE;
            end else begin
              idx_d = AddrW'(1);
            end
          end else begin
            cmd.rd_en = 1'b1;
            state_d   = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        cmd.load = 1'b1;
        cmd.src  = SRC_RAM;
        cmd.last = is_last;
        if (is_last) begin
          state_d = S_IDLE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_DRAIN;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid flag follows loads and accepted results.
  always_comb begin
    if (cmd.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o       = cmd;
  assign rd_addr_o   = idx_q;
  assign out_valid_o = out_valid_q;

endmodule

@@ dv/mbsp_msg_checker.sv @@
// Checker that predicts the MIDI parser's message bytes and compares them at the output port.
`timescale 1ns / 1ps

module mbsp_msg_checker #(
  parameter int DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  mbsp_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  mbsp_pkg::out_item_t out_item_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  import mbsp_pkg::*;

  // System common statuses that carry a defined length.
  localparam logic [7:0] MTC_QUARTER   = 8'hF1;
  localparam logic [7:0] SONG_POSITION = 8'hF2;
  localparam logic [7:0] SONG_SELECT   = 8'hF3;
  localparam logic [7:0] TUNE_REQUEST  = 8'hF6;

  // Shadow copy of the parser state.
  logic [7:0]  msg_buf [DEPTH];
  int unsigned fill;
  logic [7:0]  run_status;
  logic        truncated;

  // Message bytes predicted but not yet seen at the output.
  out_item_t   expected_bytes [$];
  int          errors;

  // Length of a complete message for a given status byte; zero if undefined.
  function automatic int unsigned status_length(input logic [7:0] s);
    if (s < STATUS_BIT) return 0;
    // Program change and channel pressure (0xC0..0xDF) have one data byte.
    if (s < SYSEX_START) return (s[7:5] == 3'b110) ? 2 : 3;
    case (s)
      MTC_QUARTER, SONG_SELECT: return 2;
      SONG_POSITION:            return 3;
      TUNE_REQUEST:             return 1;
      default:                  return 0;
    endcase
  endfunction

  task automatic queue_msg_byte(input logic [7:0] b, input logic last,
                                input logic [63:0] ts, input logic trunc);
    out_item_t e;
    e.msg_byte        = b;
    e.last_of_message = last;
    e.msg_time        = ts;
    e.sysex_truncated = trunc;
    expected_bytes = {expected_bytes, e};
  endtask

  // Emit the buffered message and empty the buffer.
  task automatic flush_message(input logic [63:0] ts);
    for (int unsigned i = 0; i < fill; i++) begin
      queue_msg_byte(msg_buf[i], (i + 1 == fill), ts, truncated);
    end
    fill      = 0;
    truncated = 1'b0;
  endtask

  // Advance the shadow state by one MIDI byte and queue what it completes.
  task automatic parse_midi_byte(input logic [7:0] b, input logic [63:0] ts);
    int unsigned need;
    // Realtime bytes leave at once and leave the assembly untouched.
    if (b >= REALTIME_FIRST) begin
      queue_msg_byte(b, 1'b1, ts, 1'b0);
      return;
    end
    // Inside sysex everything but the end byte is content.
    if (fill != 0 && msg_buf[0] == SYSEX_START) begin
      if (b == SYSEX_END) begin
        if (fill < DEPTH) begin
          msg_buf[fill] = b;
          fill++;
        end
        flush_message(ts);
      end else if (fill < DEPTH - 1) begin
        msg_buf[fill] = b;
        fill++;
      end else begin
        truncated = 1'b1;
      end
      return;
    end
    if (b >= STATUS_BIT) begin
      // A new status abandons any partial message.
      run_status = (b < SYSEX_START) ? b : 8'h00;
      msg_buf[0] = b;
      fill       = 1;
      truncated  = 1'b0;
    end else begin
      if (fill == 0) begin
        // Stray data byte unless running status supplies the status.
        if (run_status == 8'h00) return;
        msg_buf[0] = run_status;
        fill       = 1;
      end
      if (fill < DEPTH) begin
        msg_buf[fill] = b;
        fill++;
      end
    end
    if (msg_buf[0] == SYSEX_START) return;
    need = status_length(msg_buf[0]);
    if (need == 0) begin
      fill = 0;
    end else if (fill >= need) begin
      flush_message(ts);
    end
  endtask

  // Predict on every accepted input item, compare every accepted output item.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill       = 0;
      run_status = 8'h00;
      truncated  = 1'b0;
      errors     = 0;
      expected_bytes.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        parse_midi_byte(in_item_i.byte_value, in_item_i.time_stamp);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected item: msg_byte %02h", out_item_i.msg_byte);
          errors++;
        end else begin
          out_item_t e;
          e = expected_bytes.pop_front();
          if (out_item_i.msg_byte !== e.msg_byte) begin
            $error("msg_byte: expected %02h, actual %02h", e.msg_byte, out_item_i.msg_byte);
            errors++;
          end
          if (out_item_i.last_of_message !== e.last_of_message) begin
            $error("last_of_message: expected %0b, actual %0b",
                   e.last_of_message, out_item_i.last_of_message);
            errors++;
          end
          if (out_item_i.msg_time !== e.msg_time) begin
            $error("msg_time: expected %016h, actual %016h", e.msg_time, out_item_i.msg_time);
            errors++;
          end
          if (out_item_i.sysex_truncated !== e.sysex_truncated) begin
            $error("sysex_truncated: expected %0b, actual %0b",
                   e.sysex_truncated, out_item_i.sysex_truncated);
            errors++;
          end
        end
      end
      pending_o    <= expected_bytes.size();
      fail_count_o <= errors;
    end
  end

endmodule

@@ dv/tb_midi_byte_stream_parser_top.sv @@
// Testbench top for the MIDI byte stream parser: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_midi_byte_stream_parser_top;
  import mbsp_pkg::*;

  localparam int BUF_DEPTH    = 64;
  localparam int TOTAL_ITEMS  = 110;
  // Longest legal quiet stretch is the receiver hold-off plus a few gaps.
  localparam int HOLD_CYCLES  = 400;
  localparam int PRESSURE_AT  = 60;
  localparam int IDLE_LIMIT   = 4000;
  // Wait long enough for a full sysex to drain.
  localparam int DRAIN_CYCLES = 2 * BUF_DEPTH + 16;

  localparam logic [7:0] MTC_QUARTER   = 8'hF1;
  localparam logic [7:0] SONG_POSITION = 8'hF2;
  localparam logic [7:0] SONG_SELECT   = 8'hF3;
  localparam logic [7:0] UNDEF_F4      = 8'hF4;
  localparam logic [7:0] UNDEF_F5      = 8'hF5;
  localparam logic [7:0] TUNE_REQUEST  = 8'hF6;

  localparam int N_DIRECTED = 26;
  // Note on, running status, realtime mid-message, song position, tune request,
  // undefined statuses cancelling running status, new status mid-message, and a
  // sysex carrying a status byte and a realtime byte.
  localparam logic [7:0] DIRECTED_BYTES [N_DIRECTED] = '{
    8'h00, 8'h90, 8'h3C, 8'h7F, 8'h10, 8'h20, 8'h80, 8'hF8, 8'h00, 8'h7F,
    SONG_POSITION, 8'h01, 8'h02, TUNE_REQUEST, UNDEF_F5, SYSEX_END, 8'h55,
    8'hE0, 8'h11, 8'hB0, 8'h22, 8'h33, SYSEX_START, 8'h90, 8'hFF, SYSEX_END
  };

  logic       clk_i      = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  in_item_t   in_item    = '0;
  logic       out_ready  = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  out_item_t  out_item_o;
  int         fail_count;
  int         pending;

  logic       sender_burst = 1'b0;
  logic       recv_burst   = 1'b0;
  logic       held         = 1'b0;
  int         sent         = 0;
  int         out_seen     = 0;

  midi_byte_stream_parser_top #(
    .BUFFER_DEPTH(BUF_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_item_o (out_item_o)
  );

  mbsp_msg_checker #(
    .DEPTH(BUF_DEPTH)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready_o),
    .in_item_i   (in_item),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready),
    .out_item_i  (out_item_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [63:0] rand_stamp();
    case ($urandom_range(0, 19))
      0:       return 64'd0;
      1:       return {64{1'b1}};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [7:0] data7();
    return 8'($urandom_range(0, 127));
  endfunction

  // Sysex content is mostly data with the odd non-realtime status byte.
  function automatic logic [7:0] sysex_content();
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(STATUS_BIT, TUNE_REQUEST));
    return data7();
  endfunction

  // Offer one item after a random gap and hold it until it is taken.
  task automatic send_byte(input logic [7:0] b, input logic [63:0] ts);
    int       gap;
    in_item_t item;
    gap = sender_burst ? 0 : $urandom_range(0, 6);
    item.byte_value = b;
    item.time_stamp = ts;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Send a byte with a random stamp, sometimes preceded by a realtime byte.
  task automatic put_byte(input logic [7:0] b);
    if ($urandom_range(0, 11) == 0) begin
      send_byte(8'($urandom_range(REALTIME_FIRST, 8'hFF)), rand_stamp());
    end
    send_byte(b, rand_stamp());
    sent++;
  endtask

  // Stimulus and verdict.
  initial begin
    int         n;
    logic [7:0] st;
    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed part, with the stamp extremes on the first and last item.
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_byte(DIRECTED_BYTES[i],
                (i == 0) ? 64'd0 : (i == N_DIRECTED - 1) ? {64{1'b1}} : rand_stamp());
      sent++;
    end

    // One sysex a byte longer than the buffer holds, so one content byte is dropped
    // and the end byte still takes the last slot.
    put_byte(SYSEX_START);
    repeat (BUF_DEPTH - 1) put_byte(sysex_content());
    put_byte(SYSEX_END);

    // Random part: mostly well-formed messages, some broken ones and noise.
    while (sent < TOTAL_ITEMS) begin
      sender_burst = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // Channel message, sometimes continued under running status.
          st = 8'($urandom_range(8'h80, 8'hEF));
          n  = (st[7:5] == 3'b110) ? 1 : 2;
          put_byte(st);
          repeat (n) put_byte(data7());
          if ($urandom_range(0, 1) == 1) begin
            repeat ($urandom_range(1, 3) * n) put_byte(data7());
          end
        end
        4: begin
          case ($urandom_range(0, 3))
            0: begin
              put_byte(MTC_QUARTER);
              put_byte(data7());
            end
            1: begin
              put_byte(SONG_POSITION);
              put_byte(data7());
              put_byte(data7());
            end
            2: begin
              put_byte(SONG_SELECT);
              put_byte(data7());
            end
            default: put_byte(TUNE_REQUEST);
          endcase
        end
        5: begin
          put_byte(SYSEX_START);
          repeat ($urandom_range(0, 8)) put_byte(sysex_content());
          put_byte(SYSEX_END);
        end
        6: begin
          // Message cut short; the next status abandons it.
          st = ($urandom_range(0, 3) == 0) ? SONG_POSITION : 8'($urandom_range(8'h80, 8'hEF));
          put_byte(st);
          if ((st[7:5] != 3'b110) && $urandom_range(0, 1) == 1) put_byte(data7());
        end
        7: begin
          case ($urandom_range(0, 2))
            0:       put_byte(UNDEF_F4);
            1:       put_byte(UNDEF_F5);
            default: put_byte(SYSEX_END);
          endcase
          put_byte(data7());
        end
        default: begin
          repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)));
        end
      endcase
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Receiver: random wait per item, bursts with no wait, and one long hold-off.
  initial begin
    int gap;
    wait (rst_n);
    @(posedge clk_i);
    forever begin
      if (out_seen % 16 == 0) recv_burst = ($urandom_range(0, 2) == 0);
      if (out_seen == PRESSURE_AT && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      gap = recv_burst ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      out_seen++;
    end
  end

  // Watchdog on cycles with no handshake on either channel.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
      if (idle >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

endmodule
